FILE: hw/rtl/utf8sf_pkg.sv
package utf8sf_pkg;

    typedef logic [7:0]      byte_t;
    typedef logic [3:0][7:0] win_t;

    // result of one look at the head of the window
    typedef struct packed {
        logic [2:0] len;
        logic       bad;
        logic       complete;
    } chk_t;

    localparam byte_t REPL_B0     = 8'hEF;
    localparam byte_t REPL_B1     = 8'hBF;
    localparam byte_t REPL_B2     = 8'hBD;
    localparam byte_t LEAD2_LO    = 8'hC2;
    localparam byte_t LEAD2_HI    = 8'hDF;
    localparam byte_t LEAD3_LO    = 8'hE0;
    localparam byte_t LEAD3_HI    = 8'hEF;
    localparam byte_t LEAD4_LO    = 8'hF0;
    localparam byte_t LEAD4_HI    = 8'hF4;
    localparam byte_t LEAD_SURR   = 8'hED;
    localparam byte_t MIN_E0      = 8'hA0;
    localparam byte_t MIN_F0      = 8'h90;
    localparam byte_t MAX_F4      = 8'h8F;
    localparam byte_t CONT_MASK   = 8'hC0;
    localparam byte_t CONT_TAG    = 8'h80;
    localparam byte_t ASCII_LIMIT = 8'h80;

    function automatic logic [2:0] lead_len(input byte_t b);
        logic [2:0] l;
        l = 3'd0;
        if (b < ASCII_LIMIT) l = 3'd1;
        else if (b >= LEAD2_LO && b <= LEAD2_HI) l = 3'd2;
        else if (b >= LEAD3_LO && b <= LEAD3_HI) l = 3'd3;
        else if (b >= LEAD4_LO && b <= LEAD4_HI) l = 3'd4;
        return l;
    endfunction

    // second: byte sits right after the lead, where the range rules apply
    function automatic logic follow_ok(input byte_t lead, input logic second, input byte_t b);
        logic ok;
        ok = ((b & CONT_MASK) == CONT_TAG);
        if (second) begin
            if (lead == LEAD3_LO && b < MIN_E0) ok = 1'b0;
            if (lead == LEAD_SURR && b >= MIN_E0) ok = 1'b0;
            if (lead == LEAD4_LO && b < MIN_F0) ok = 1'b0;
            if (lead == LEAD4_HI && b > MAX_F4) ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic byte_t repl_byte(input logic [1:0] idx);
        byte_t r;
        unique case (idx)
            2'd0:    r = REPL_B0;
            2'd1:    r = REPL_B1;
            default: r = REPL_B2;
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/utf8sf_check.sv
module utf8sf_check
    import utf8sf_pkg::*;
(
    input  win_t       win,
    input  logic [2:0] n,
    output chk_t       chk
);

    logic [2:0] len;
    logic       bad_follow;

    always_comb begin
        len        = lead_len(win[0]);
        bad_follow = 1'b0;
        for (int j = 1; j < 4; j++) begin
            if (3'(j) < len && 3'(j) < n && !follow_ok(win[0], (j == 1), win[j])) begin
                bad_follow = 1'b1;
            end
        end
        chk.len      = len;
        chk.bad      = (len == 3'd0) || bad_follow;
        chk.complete = (len <= n);
    end

endmodule

FILE: hw/rtl/utf8_stream_filter_unit.sv
// utf8 stream filter: cleans a byte string into well-formed utf-8
//
// s_ channel: one request per raw byte, s_in_last on the final byte of a string
// m_ channel: filtered bytes; m_out_valid 0 marks an empty end marker,
//   m_out_last flags the final result, m_string_valid tells on it whether the
//   string had no dropped byte
// cfg channel: replace_enable, 1 emits ef bf bd for each dropped byte;
//   write it only while the block is idle
// timing: a byte is taken only in the idle state; each request then passes
//   through a scan step for each look at the window head (the look that
//   finds the window empty included), an output step for each byte put out
//   (a sequence byte or a replacement byte) and a closing step; the next byte
//   is taken only after that, since the shared head checker and the single
//   output port serve one request at a time
// the last produced byte is held back in a hold slot so out_last can be put on it
// stalls: when m_ready is low the sequencer waits with the output register full
// reset: pending bytes, flags and replace_enable go to zero, output goes empty
module utf8_stream_filter_unit
    import utf8sf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_out_last,
    output logic       m_string_valid,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_replace_enable
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_REPL,
        ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    win_t       win_reg, win_next;       // window, head at index 0
    logic [2:0] n_reg, n_next;           // bytes in the window
    logic [2:0] cnt_reg, cnt_next;       // bytes left to emit, or replacement index
    logic       last_reg, last_next;
    logic       saw_invalid_reg, saw_invalid_next;
    logic       replace_reg, replace_next;
    byte_t      hold_byte_reg, hold_byte_next;
    logic       hold_valid_reg, hold_valid_next;

    logic       m_valid_reg, m_valid_next;
    byte_t      m_byte_reg, m_byte_next;
    logic       m_ov_reg, m_ov_next;
    logic       m_last_reg, m_last_next;
    logic       m_sv_reg, m_sv_next;

    chk_t       chk;
    logic       out_free;
    logic       put_en;
    byte_t      put_byte;

    // shared head checker, used once per scan step
    utf8sf_check u_check (
        .win (win_reg),
        .n   (n_reg),
        .chk (chk)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        win_next         = win_reg;
        n_next           = n_reg;
        cnt_next         = cnt_reg;
        last_next        = last_reg;
        saw_invalid_next = saw_invalid_reg;
        replace_next     = replace_reg;
        hold_byte_next   = hold_byte_reg;
        hold_valid_next  = hold_valid_reg;
        m_valid_next     = m_valid_reg;
        m_byte_next      = m_byte_reg;
        m_ov_next        = m_ov_reg;
        m_last_next      = m_last_reg;
        m_sv_next        = m_sv_reg;
        put_en           = 1'b0;
        put_byte         = '0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (cfg_valid) replace_next = cfg_replace_enable;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // pending bytes already sit at the front of the window
                    win_next[n_reg[1:0]] = s_in_byte;
                    n_next               = n_reg + 3'd1;
                    last_next            = s_in_last;
                    state_next           = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (n_reg == 3'd0) begin
                    state_next = ST_FINISH;
                end else if (!chk.bad && chk.complete) begin
                    cnt_next   = chk.len;
                    state_next = ST_EMIT;
                end else if (!chk.bad && !last_reg) begin
                    // valid prefix waits for the next request
                    state_next = ST_FINISH;
                end else begin
                    // drop the head byte
                    saw_invalid_next = 1'b1;
                    win_next         = {8'h00, win_reg[3:1]};
                    n_next           = n_reg - 3'd1;
                    if (replace_reg) begin
                        cnt_next   = 3'd0;
                        state_next = ST_REPL;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    put_byte = win_reg[0];
                    win_next = {8'h00, win_reg[3:1]};
                    n_next   = n_reg - 3'd1;
                    cnt_next = cnt_reg - 3'd1;
                    if (cnt_reg == 3'd1) state_next = ST_SCAN;
                end
            end
            ST_REPL: begin
                if (out_free) begin
                    put_en   = 1'b1;
                    put_byte = repl_byte(cnt_reg[1:0]);
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd2) state_next = ST_SCAN;
                end
            end
            ST_FINISH: begin
                if (last_reg) begin
                    if (out_free) begin
                        // final result, or empty end marker when nothing came out
                        m_valid_next     = 1'b1;
                        m_byte_next      = hold_valid_reg ? hold_byte_reg : 8'h00;
                        m_ov_next        = hold_valid_reg;
                        m_last_next      = 1'b1;
                        m_sv_next        = !saw_invalid_reg;
                        hold_valid_next  = 1'b0;
                        n_next           = 3'd0;
                        win_next         = '0;
                        saw_invalid_next = 1'b0;
                        state_next       = ST_IDLE;
                    end
                end else if (hold_valid_reg) begin
                    if (out_free) begin
                        m_valid_next    = 1'b1;
                        m_byte_next     = hold_byte_reg;
                        m_ov_next       = 1'b1;
                        m_last_next     = 1'b0;
                        m_sv_next       = 1'b0;
                        hold_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // new byte goes to the hold slot, the one it replaces goes out
        if (put_en) begin
            if (hold_valid_reg) begin
                m_valid_next = 1'b1;
                m_byte_next  = hold_byte_reg;
                m_ov_next    = 1'b1;
                m_last_next  = 1'b0;
                m_sv_next    = 1'b0;
            end
            hold_byte_next  = put_byte;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            win_reg         <= '0;
            n_reg           <= '0;
            cnt_reg         <= '0;
            last_reg        <= 1'b0;
            saw_invalid_reg <= 1'b0;
            replace_reg     <= 1'b0;
            hold_byte_reg   <= '0;
            hold_valid_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
            m_byte_reg      <= '0;
            m_ov_reg        <= 1'b0;
            m_last_reg      <= 1'b0;
            m_sv_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            win_reg         <= win_next;
            n_reg           <= n_next;
            cnt_reg         <= cnt_next;
            last_reg        <= last_next;
            saw_invalid_reg <= saw_invalid_next;
            replace_reg     <= replace_next;
            hold_byte_reg   <= hold_byte_next;
            hold_valid_reg  <= hold_valid_next;
            m_valid_reg     <= m_valid_next;
            m_byte_reg      <= m_byte_next;
            m_ov_reg        <= m_ov_next;
            m_last_reg      <= m_last_next;
            m_sv_reg        <= m_sv_next;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_out_valid    = m_ov_reg;
    assign m_out_last     = m_last_reg;
    assign m_string_valid = m_sv_reg;

`ifndef SYNTHESIS
    // nothing is held back once a request is finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_valid_reg)
        else $error("hold slot still full while idle");

    // a finished request never leaves a full window pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (n_reg <= 3'd3))
        else $error("pending window overflow");

    // an empty end marker is only ever the final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_valid) |-> m_out_last)
        else $error("empty marker without last flag");

    // string status is only reported on the final result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_out_last) |-> !m_string_valid)
        else $error("string status outside final result");
`endif

endmodule
